@@ rtl/ppdm_pkg.sv @@
// Package for the PWM period and duty meter: widths, codes and the sequencer state type.
// Used by pwm_period_duty_meter. It has no dependencies of its own.
package ppdm_pkg;

  localparam int COUNTER_BITS = 32;                  // free-running counter width, 16..32
  localparam int TICK_W       = COUNTER_BITS + 8;    // phase tick count incl. 8 wrap bits
  localparam int PER_W        = TICK_W + 1;          // period = high + low
  localparam int RATE_W       = 28;                  // tick_rate_hz register
  localparam int FNUM_W       = 38;                  // tick_rate * 1000, also frequency width
  localparam int DUTY_W       = 10;                  // duty quotient bits (value <= 1000)
  localparam int DNUM_W       = TICK_W + DUTY_W;     // high_ticks * 1000
  localparam int NUM_W        = (FNUM_W > DNUM_W) ? FNUM_W : DNUM_W;
  localparam int OUT_TICK_W   = 40;                  // width of the tick count ports
  localparam int WRAP_W       = 8;
  localparam int CNT_W        = $clog2(FNUM_W);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);
  localparam logic [WRAP_W-1:0] WRAP_MAX   = '1;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = DUTY_W'(1000);

  // Input operation codes.
  localparam logic OP_WRAP = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // Edge phase codes; the fourth code is treated as waiting for a rising edge.
  localparam logic [1:0] PH_WAIT_RISE = 2'd0;
  localparam logic [1:0] PH_WAIT_FALL = 2'd1;
  localparam logic [1:0] PH_WAIT_END  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVF,
    ST_DIVD,
    ST_FIN
  } state_t;

  // x * 1000 as shift and subtract: 1000 = 1024 - 16 - 8.
  function automatic logic [NUM_W-1:0] times_1000(input logic [NUM_W-1:0] x);
    times_1000 = (x << 10) - (x << 4) - (x << 3);
  endfunction

endpackage

@@ rtl/pwm_period_duty_meter.sv @@
// PWM period and duty meter: input-capture edges and counter wraps in, one measurement out.
// Depends on ppdm_pkg for widths, codes, the state type and the multiply-by-1000 helper.
//
// Overflow ticks and the opening rising and falling edges of a measurement are handled in the idle state.
// The closing edge starts the shared restoring divider: a setup step, the frequency
// quotient, then the duty quotient, and a final step that loads the output register.
// The input stalls meanwhile, and longer while an earlier result still waits on a stalled
// receiver. The divider does one subtract-and-compare per cycle. A zero period skips
// the divider and goes from the setup step straight to the output load.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears phase and wrap
// counts and the stamps, and reloads tick_rate_hz to 1 MHz.
module pwm_period_duty_meter (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppdm_pkg::RATE_W-1:0]         cfg_tick_rate_hz,
  // Input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [31:0]                         in_capture_value,
  // Result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ppdm_pkg::OUT_TICK_W-1:0]     out_high_ticks,
  output logic [ppdm_pkg::OUT_TICK_W-1:0]     out_low_ticks,
  output logic [ppdm_pkg::FNUM_W-1:0]         out_freq_millihz,
  output logic [ppdm_pkg::DUTY_W-1:0]         out_duty_tenths,
  output logic                                out_period_zero
);

  localparam int CB = ppdm_pkg::COUNTER_BITS;

  // Control state.
  ppdm_pkg::state_t                  state_r, state_nxt;
  logic [1:0]                        phase_r, phase_nxt;
  logic [ppdm_pkg::WRAP_W-1:0]       hi_wraps_r, hi_wraps_nxt;
  logic [ppdm_pkg::WRAP_W-1:0]       lo_wraps_r, lo_wraps_nxt;
  logic [ppdm_pkg::RATE_W-1:0]       rate_r, rate_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [CB-1:0]                     rise_r, rise_nxt;
  logic [CB-1:0]                     fall_r, fall_nxt;

  // Measurement and divider datapath.
  logic [ppdm_pkg::TICK_W-1:0]       hi_r, hi_nxt;
  logic [ppdm_pkg::TICK_W-1:0]       lo_r, lo_nxt;
  logic [ppdm_pkg::PER_W-1:0]        period_r, period_nxt;
  logic [ppdm_pkg::NUM_W-1:0]        dnum_r, dnum_nxt;
  logic [ppdm_pkg::NUM_W-1:0]        num_r, num_nxt;
  logic [ppdm_pkg::PER_W-1:0]        rem_r, rem_nxt;
  logic [ppdm_pkg::FNUM_W-1:0]       quo_r, quo_nxt;
  logic [ppdm_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ppdm_pkg::FNUM_W-1:0]       freq_r, freq_nxt;
  logic                              pzero_r, pzero_nxt;

  // Output register.
  logic [ppdm_pkg::OUT_TICK_W-1:0]   out_hi_r, out_hi_nxt;
  logic [ppdm_pkg::OUT_TICK_W-1:0]   out_lo_r, out_lo_nxt;
  logic [ppdm_pkg::FNUM_W-1:0]       out_freq_r, out_freq_nxt;
  logic [ppdm_pkg::DUTY_W-1:0]       out_duty_r, out_duty_nxt;
  logic                              out_pz_r, out_pz_nxt;

  // Combinational helpers.
  logic                              in_acc;
  logic [1:0]                        phase_eff;
  logic [CB-1:0]                     cap;
  logic [ppdm_pkg::PER_W:0]          div_shift;
  logic [ppdm_pkg::PER_W:0]          div_diff;
  logic                              div_bit;
  logic [ppdm_pkg::PER_W-1:0]        div_rem;
  logic [ppdm_pkg::FNUM_W-1:0]       quo_step;
  logic [ppdm_pkg::PER_W-1:0]        period_sum;
  logic [ppdm_pkg::NUM_W-1:0]        dnum_calc;
  logic [ppdm_pkg::NUM_W-1:0]        fnum_calc;

  // Always writable, so the user must send writes only while idle; the block has no check.
  assign cfg_ready = 1'b1;

  assign in_stall = (state_r != ppdm_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cap      = in_capture_value[CB-1:0];
  assign phase_eff = (phase_r == ppdm_pkg::PH_WAIT_RISE || phase_r == ppdm_pkg::PH_WAIT_FALL ||
                      phase_r == ppdm_pkg::PH_WAIT_END) ? phase_r : ppdm_pkg::PH_WAIT_RISE;

  // The shared unit: one restoring-division step. The remainder stays below the
  // period, so shifting in the next numerator bit needs one extra bit.
  assign div_shift = {rem_r, num_r[ppdm_pkg::NUM_W-1]};
  assign div_diff  = div_shift - {1'b0, period_r};
  assign div_bit   = !div_diff[ppdm_pkg::PER_W];
  assign div_rem   = div_bit ? div_diff[ppdm_pkg::PER_W-1:0] : div_shift[ppdm_pkg::PER_W-1:0];
  assign quo_step  = {quo_r[ppdm_pkg::FNUM_W-2:0], div_bit};

  assign period_sum = {1'b0, hi_r} + {1'b0, lo_r};
  assign fnum_calc  = ppdm_pkg::times_1000(ppdm_pkg::NUM_W'(rate_r));
  assign dnum_calc  = ppdm_pkg::times_1000(ppdm_pkg::NUM_W'(hi_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppdm_pkg::ST_IDLE;
      phase_r     <= ppdm_pkg::PH_WAIT_RISE;
      hi_wraps_r  <= '0;
      lo_wraps_r  <= '0;
      rate_r      <= ppdm_pkg::RATE_RESET;
      out_valid_r <= 1'b0;
      rise_r      <= '0;
      fall_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hi_wraps_r  <= hi_wraps_nxt;
      lo_wraps_r  <= lo_wraps_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    period_r   <= period_nxt;
    dnum_r     <= dnum_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    freq_r     <= freq_nxt;
    pzero_r    <= pzero_nxt;
    out_hi_r   <= out_hi_nxt;
    out_lo_r   <= out_lo_nxt;
    out_freq_r <= out_freq_nxt;
    out_duty_r <= out_duty_nxt;
    out_pz_r   <= out_pz_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    hi_wraps_nxt  = hi_wraps_r;
    lo_wraps_nxt  = lo_wraps_r;
    rate_nxt      = rate_r;
    out_valid_nxt = out_valid_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    period_nxt    = period_r;
    dnum_nxt      = dnum_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    freq_nxt      = freq_r;
    pzero_nxt     = pzero_r;
    out_hi_nxt    = out_hi_r;
    out_lo_nxt    = out_lo_r;
    out_freq_nxt  = out_freq_r;
    out_duty_nxt  = out_duty_r;
    out_pz_nxt    = out_pz_r;

    if (cfg_valid && cfg_ready) begin
      rate_nxt = cfg_tick_rate_hz;
    end

    // The consumer took the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ppdm_pkg::ST_IDLE: begin
        if (in_acc) begin
          phase_nxt = phase_eff;
          if (in_op == ppdm_pkg::OP_WRAP) begin
            // Count a counter wrap against the phase in progress, saturating.
            if (phase_eff == ppdm_pkg::PH_WAIT_FALL && hi_wraps_r != ppdm_pkg::WRAP_MAX) begin
              hi_wraps_nxt = hi_wraps_r + 1'b1;
            end else if (phase_eff == ppdm_pkg::PH_WAIT_END &&
                         lo_wraps_r != ppdm_pkg::WRAP_MAX) begin
              lo_wraps_nxt = lo_wraps_r + 1'b1;
            end
          end else if (phase_eff == ppdm_pkg::PH_WAIT_FALL) begin
            fall_nxt  = cap;
            phase_nxt = ppdm_pkg::PH_WAIT_END;
          end else if (phase_eff == ppdm_pkg::PH_WAIT_END) begin
            // Closing rising edge: both spans wrap modulo the tick count width.
            hi_nxt = {hi_wraps_r, {CB{1'b0}}} + ppdm_pkg::TICK_W'(fall_r)
                     - ppdm_pkg::TICK_W'(rise_r);
            lo_nxt = {lo_wraps_r, {CB{1'b0}}} + ppdm_pkg::TICK_W'(cap)
                     - ppdm_pkg::TICK_W'(fall_r);
            phase_nxt    = ppdm_pkg::PH_WAIT_RISE;
            hi_wraps_nxt = '0;
            lo_wraps_nxt = '0;
            state_nxt    = ppdm_pkg::ST_SETUP;
          end else begin
            rise_nxt     = cap;
            hi_wraps_nxt = '0;
            lo_wraps_nxt = '0;
            phase_nxt    = ppdm_pkg::PH_WAIT_FALL;
          end
        end
      end

      ppdm_pkg::ST_SETUP: begin
        period_nxt = period_sum;
        dnum_nxt   = dnum_calc;
        rem_nxt    = '0;
        quo_nxt    = '0;
        num_nxt    = fnum_calc << (ppdm_pkg::NUM_W - ppdm_pkg::FNUM_W);
        cnt_nxt    = ppdm_pkg::CNT_W'(ppdm_pkg::FNUM_W - 1);
        if (period_sum == '0) begin
          pzero_nxt = 1'b1;
          freq_nxt  = '0;
          quo_nxt   = '0;
          state_nxt = ppdm_pkg::ST_FIN;
        end else begin
          pzero_nxt = 1'b0;
          state_nxt = ppdm_pkg::ST_DIVF;
        end
      end

      ppdm_pkg::ST_DIVF: begin
        rem_nxt = div_rem;
        quo_nxt = quo_step;
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // Frequency done. The duty quotient is below 1024, so its numerator's upper
          // part is already below the period and only the low ten bits need steps.
          freq_nxt  = quo_step;
          rem_nxt   = ppdm_pkg::PER_W'(dnum_r >> ppdm_pkg::DUTY_W);
          num_nxt   = ppdm_pkg::NUM_W'(dnum_r[ppdm_pkg::DUTY_W-1:0])
                      << (ppdm_pkg::NUM_W - ppdm_pkg::DUTY_W);
          quo_nxt   = '0;
          cnt_nxt   = ppdm_pkg::CNT_W'(ppdm_pkg::DUTY_W - 1);
          state_nxt = ppdm_pkg::ST_DIVD;
        end
      end

      ppdm_pkg::ST_DIVD: begin
        rem_nxt = div_rem;
        quo_nxt = quo_step;
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ppdm_pkg::ST_FIN;
        end
      end

      ppdm_pkg::ST_FIN: begin
        // Load the output register once it is free or being emptied this cycle.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hi_nxt    = ppdm_pkg::OUT_TICK_W'(hi_r);
          out_lo_nxt    = ppdm_pkg::OUT_TICK_W'(lo_r);
          out_freq_nxt  = freq_r;
          out_duty_nxt  = quo_r[ppdm_pkg::DUTY_W-1:0];
          out_pz_nxt    = pzero_r;
          state_nxt     = ppdm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ppdm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_high_ticks   = out_hi_r;
  assign out_low_ticks    = out_lo_r;
  assign out_freq_millihz = out_freq_r;
  assign out_duty_tenths  = out_duty_r;
  assign out_period_zero  = out_pz_r;

  // A result only appears out of the final sequencer state.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ppdm_pkg::ST_FIN))
    else $error("result appeared outside the final state");

  // The divider remainder always stays below the divisor.
  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppdm_pkg::ST_DIVF || state_r == ppdm_pkg::ST_DIVD) |-> (rem_r < period_r))
    else $error("divider remainder not below period");

  // A zero period gives zero frequency and duty.
  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pz_r) |-> (out_freq_r == '0 && out_duty_r == '0))
    else $error("zero period with nonzero frequency or duty");

  // Duty never exceeds one hundred percent.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r <= ppdm_pkg::DUTY_MAX))
    else $error("duty above one thousand tenths");

endmodule

@@ tb/sv/pwm_period_duty_meter_tb.sv @@
// Self-checking testbench for pwm_period_duty_meter: drives overflow ticks and capture
// edges and checks every measurement against a cycle-free predictor kept in this file.
// Depends on ppdm_pkg for widths and codes, and on the pwm_period_duty_meter RTL.
`timescale 1ns / 100ps

module pwm_period_duty_meter_tb;

  // Cycles allowed with no handshake on any channel before the run is called hung. The
  // slowest legal stretch is the long receiver hold-off plus a divider pass, well below this.
  localparam int QUIET_LIMIT  = 4000;
  // Extra wait once nothing is pending; long enough to cover a divider pass.
  localparam int SETTLE_CYCLES = 64;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES  = 400;

  localparam logic [63:0] STAMP_MASK = (64'd1 << ppdm_pkg::COUNTER_BITS) - 64'd1;
  localparam logic [63:0] TICK_MASK  = (64'd1 << ppdm_pkg::TICK_W) - 64'd1;

  // One measurement as it leaves the block.
  typedef struct packed {
    logic [ppdm_pkg::OUT_TICK_W-1:0] high_ticks;
    logic [ppdm_pkg::OUT_TICK_W-1:0] low_ticks;
    logic [ppdm_pkg::FNUM_W-1:0]     freq_millihz;
    logic [ppdm_pkg::DUTY_W-1:0]     duty_tenths;
    logic                            period_zero;
  } meas_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ppdm_pkg::RATE_W-1:0]     cfg_tick_rate_hz = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_op = ppdm_pkg::OP_WRAP;
  logic [31:0]                     in_capture_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ppdm_pkg::OUT_TICK_W-1:0] out_high_ticks;
  logic [ppdm_pkg::OUT_TICK_W-1:0] out_low_ticks;
  logic [ppdm_pkg::FNUM_W-1:0]     out_freq_millihz;
  logic [ppdm_pkg::DUTY_W-1:0]     out_duty_tenths;
  logic                            out_period_zero;

  pwm_period_duty_meter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_tick_rate_hz (cfg_tick_rate_hz),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_capture_value (in_capture_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_high_ticks   (out_high_ticks),
    .out_low_ticks    (out_low_ticks),
    .out_freq_millihz (out_freq_millihz),
    .out_duty_tenths  (out_duty_tenths),
    .out_period_zero  (out_period_zero)
  );

  // The meter as the testbench sees it: edge phase, the two stamps, the per-phase
  // overflow counts and the tick rate register. Only the stimulus process writes these.
  logic [1:0]                  trk_phase = ppdm_pkg::PH_WAIT_RISE;
  logic [31:0]                 trk_rise = '0;
  logic [31:0]                 trk_fall = '0;
  logic [ppdm_pkg::WRAP_W-1:0] trk_high_wraps = '0;
  logic [ppdm_pkg::WRAP_W-1:0] trk_low_wraps = '0;
  logic [ppdm_pkg::RATE_W-1:0] trk_rate = ppdm_pkg::RATE_RESET;

  meas_t pending_meas[$];   // measurements predicted but not yet seen on the output
  int    err_count = 0;
  int    items_sent = 0;
  int    in_idle_pct = 0;    // chance that the sender pauses after an item
  int    out_stall_pct = 0;  // chance that the receiver stalls in a given cycle
  int    hold_req = 0;       // bumped by a test to ask the receiver for a long hold-off
  int    hold_done = 0;
  int    quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the tracked meter by one accepted item and queue the measurement it closes.
  task automatic track_item(input logic op, input logic [31:0] cap);
    logic [1:0]  ph;
    logic [63:0] stamp;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] per;
    meas_t       m;
    ph = (trk_phase == 2'd3) ? ppdm_pkg::PH_WAIT_RISE : trk_phase;
    stamp = 64'(cap) & STAMP_MASK;
    if (op == ppdm_pkg::OP_WRAP) begin
      // Overflows count only while a phase is being timed, and stick at the top.
      if (ph == ppdm_pkg::PH_WAIT_FALL && trk_high_wraps != ppdm_pkg::WRAP_MAX)
        trk_high_wraps++;
      if (ph == ppdm_pkg::PH_WAIT_END && trk_low_wraps != ppdm_pkg::WRAP_MAX)
        trk_low_wraps++;
      trk_phase = ph;
    end else begin
      case (ph)
        ppdm_pkg::PH_WAIT_RISE: begin
          trk_rise = stamp[31:0];
          trk_high_wraps = '0;
          trk_low_wraps = '0;
          trk_phase = ppdm_pkg::PH_WAIT_FALL;
        end
        ppdm_pkg::PH_WAIT_FALL: begin
          trk_fall = stamp[31:0];
          trk_phase = ppdm_pkg::PH_WAIT_END;
        end
        default: begin
          // Each wrap is worth a full counter span; a stamp below its predecessor
          // simply wraps the 40-bit count.
          hi = ((64'(trk_high_wraps) << ppdm_pkg::COUNTER_BITS) + 64'(trk_fall)
                - 64'(trk_rise)) & TICK_MASK;
          lo = ((64'(trk_low_wraps) << ppdm_pkg::COUNTER_BITS) + stamp - 64'(trk_fall))
               & TICK_MASK;
          per = hi + lo;
          m.high_ticks = hi[ppdm_pkg::OUT_TICK_W-1:0];
          m.low_ticks  = lo[ppdm_pkg::OUT_TICK_W-1:0];
          if (per == 64'd0) begin
            m.freq_millihz = '0;
            m.duty_tenths  = '0;
            m.period_zero  = 1'b1;
          end else begin
            m.freq_millihz = ppdm_pkg::FNUM_W'((64'(trk_rate) * 64'd1000) / per);
            m.duty_tenths  = ppdm_pkg::DUTY_W'((hi * 64'd1000) / per);
            m.period_zero  = 1'b0;
          end
          pending_meas.push_back(m);
          trk_phase = ppdm_pkg::PH_WAIT_RISE;
          trk_high_wraps = '0;
          trk_low_wraps = '0;
        end
      endcase
    end
  endtask

  // Offer one item, wait for the block to take it, then maybe leave a gap. With no gap
  // valid stays high, so valid is never dropped and raised in the same step.
  task automatic send_item(input logic op, input logic [31:0] cap);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_capture_value <= cap;
    do @(posedge clk); while (in_stall);
    track_item(op, cap);
    items_sent++;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering items and let every expected measurement and any other item drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_meas.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The rate register is only touched with the block idle.
  task automatic write_rate(input logic [ppdm_pkg::RATE_W-1:0] rate);
    settle();
    cfg_valid <= 1'b1;
    cfg_tick_rate_hz <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trk_rate = rate;
  endtask

  // A well-formed rise, fall, rise sequence with up to max_wraps overflow ticks per
  // phase. The stamp spacing is drawn from several shapes so that short, long,
  // wrapped and near-zero periods all occur.
  task automatic run_measurement(input int max_wraps);
    logic [31:0] r;
    logic [31:0] f;
    logic [31:0] e;
    int          nh;
    int          nl;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        f = $urandom;
        e = $urandom;
      end
      1: begin
        f = r + $urandom_range(0, 5000);
        e = f + $urandom_range(0, 5000);
      end
      2: begin
        f = r + $urandom_range(0, 3);
        e = f + $urandom_range(0, 3);
      end
      default: begin
        f = r + $urandom;
        e = f + $urandom_range(1, 100000);
      end
    endcase
    nh = $urandom_range(0, max_wraps);
    nl = $urandom_range(0, max_wraps);
    send_item(ppdm_pkg::OP_EDGE, r);
    repeat (nh) send_item(ppdm_pkg::OP_WRAP, $urandom);
    send_item(ppdm_pkg::OP_EDGE, f);
    repeat (nl) send_item(ppdm_pkg::OP_WRAP, $urandom);
    send_item(ppdm_pkg::OP_EDGE, e);
  endtask

  // Directed cases: an overflow while idle, an ordinary pulse, a zero period, a rising
  // stamp above the falling one, counter extremes with overflows, zero duty and full duty.
  task automatic test_directed_cases();
    send_item(ppdm_pkg::OP_WRAP, 32'hFFFF_FFFF);
    send_item(ppdm_pkg::OP_EDGE, 32'd100);
    send_item(ppdm_pkg::OP_EDGE, 32'd350);
    send_item(ppdm_pkg::OP_EDGE, 32'd1100);
    send_item(ppdm_pkg::OP_EDGE, 32'd5);
    send_item(ppdm_pkg::OP_EDGE, 32'd5);
    send_item(ppdm_pkg::OP_EDGE, 32'd5);
    send_item(ppdm_pkg::OP_EDGE, 32'hFFFF_FFF0);
    send_item(ppdm_pkg::OP_EDGE, 32'h0000_0010);
    send_item(ppdm_pkg::OP_EDGE, 32'h0000_0020);
    send_item(ppdm_pkg::OP_EDGE, 32'h0000_0000);
    send_item(ppdm_pkg::OP_WRAP, 32'h0000_0000);
    send_item(ppdm_pkg::OP_EDGE, 32'hFFFF_FFFF);
    send_item(ppdm_pkg::OP_WRAP, 32'h5555_AAAA);
    send_item(ppdm_pkg::OP_EDGE, 32'h0000_0000);
    send_item(ppdm_pkg::OP_EDGE, 32'hFFFF_FFFF);
    send_item(ppdm_pkg::OP_EDGE, 32'hFFFF_FFFF);
    send_item(ppdm_pkg::OP_EDGE, 32'h0000_0000);
    send_item(ppdm_pkg::OP_EDGE, 32'd10);
    send_item(ppdm_pkg::OP_EDGE, 32'd20);
    send_item(ppdm_pkg::OP_EDGE, 32'd20);
    settle();
  endtask

  // Enough overflows in each phase to pin both counts at their ceiling.
  task automatic test_wrap_saturation();
    send_item(ppdm_pkg::OP_EDGE, $urandom);
    repeat (int'(ppdm_pkg::WRAP_MAX) + 3) send_item(ppdm_pkg::OP_WRAP, $urandom);
    send_item(ppdm_pkg::OP_EDGE, $urandom);
    repeat (int'(ppdm_pkg::WRAP_MAX) + 3) send_item(ppdm_pkg::OP_WRAP, $urandom);
    send_item(ppdm_pkg::OP_EDGE, $urandom);
    settle();
  endtask

  // The rate register at its extremes, including zero, with a measurement under each.
  task automatic test_rate_settings();
    logic [ppdm_pkg::RATE_W-1:0] rates[5];
    rates = '{ppdm_pkg::RATE_W'(1), ppdm_pkg::RATE_W'(200000000), '0, '1,
              ppdm_pkg::RATE_RESET};
    foreach (rates[i]) begin
      write_rate(rates[i]);
      send_item(ppdm_pkg::OP_EDGE, 32'd1000);
      send_item(ppdm_pkg::OP_EDGE, 32'd1001);
      send_item(ppdm_pkg::OP_EDGE, 32'd1003);
      run_measurement(1);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // result register fills and the block has to stall its input.
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req++;
    repeat (6) run_measurement(0);
    settle();
  endtask

  // Random traffic in four idling phases, with a fresh tick rate for each. Most of it is
  // well-formed measurements; the rest is stray ticks and edges that break the sequence.
  task automatic test_random_traffic();
    int idle_by_phase[4];
    int stall_by_phase[4];
    int target;
    idle_by_phase = '{0, 51, 0, 7};
    stall_by_phase = '{0, 0, 51, 7};
    for (int p = 0; p < 4; p++) begin
      write_rate($urandom_range(1, 200000000));
      in_idle_pct = idle_by_phase[p];
      out_stall_pct = stall_by_phase[p];
      target = items_sent + 40;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 15)
          repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(0, 1)), $urandom);
        else
          run_measurement(($urandom_range(0, 9) == 0) ? 6 : 2);
      end
    end
    in_idle_pct = 0;
    out_stall_pct = 0;
    settle();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: a random stall each cycle, or the long hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_req;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
      end
    end
  end

  // Every measurement the block hands over is matched against the oldest prediction.
  meas_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_meas.size() == 0) begin
        err_count++;
        $display("%0t: unexpected measurement, expected none, actual high %0d low %0d",
                 $time, out_high_ticks, out_low_ticks);
      end else begin
        want = pending_meas.pop_front();
        check_field("high_ticks", 64'(want.high_ticks), 64'(out_high_ticks));
        check_field("low_ticks", 64'(want.low_ticks), 64'(out_low_ticks));
        check_field("freq_millihz", 64'(want.freq_millihz), 64'(out_freq_millihz));
        check_field("duty_tenths", 64'(want.duty_tenths), 64'(out_duty_tenths));
        check_field("period_zero", 64'(want.period_zero), 64'(out_period_zero));
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pwm_period_duty_meter_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_wrap_saturation();
    test_rate_settings();
    test_backpressure();
    test_random_traffic();
    // The last settle left nothing pending; anything arriving late is caught above.
    if (err_count == 0 && pending_meas.size() == 0) begin
      $display("pwm_period_duty_meter_tb OK");
    end else begin
      $display("pwm_period_duty_meter_tb NOT OK");
    end
    $finish;
  end

endmodule
